// File: hdl/sha1_digest_macros.svh
// ----------------------------------------------------------------------------
// sha1_digest_macros
// Assertion macros used by the SHA-1 sequencer (sha1_ctrl).
// ----------------------------------------------------------------------------
`ifndef SHA1_DIGEST_MACROS_SVH
`define SHA1_DIGEST_MACROS_SVH

// clocked check, off during reset
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// two conditions that must never hold together
`define SHA1_NEVER_BOTH(lbl, x, y, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !((x) && (y))) else $error(msg);

`endif

// File: hdl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Types, constants and round functions of the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

  localparam int unsigned ROUNDS = 80;

  localparam logic [31:0] INIT_CHAIN [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] K_0 = 32'h5A82_7999;
  localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_3 = 32'hCA62_C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h00_0000};

  // source of a word pushed into the schedule window
  typedef enum logic [2:0] {
    SRC_IN    = 3'd0,
    SRC_PAD   = 3'd1,
    SRC_ZERO  = 3'd2,
    SRC_LENHI = 3'd3,
    SRC_LENLO = 3'd4
  } src_e;

  typedef struct packed {
    logic       push;
    src_e       src;
    logic       acc_len;
    logic       rnd_load;
    logic       round_en;
    logic [6:0] round_idx;
    logic       chain_add;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // mask invalid bytes of a partial last word and append the pad byte; a full word passes unchanged
  function automatic logic [31:0] format_last(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd0:    r = PAD_WORD;
      3'd1:    r = {w[31:24], PAD_BYTE, 16'h0000};
      3'd2:    r = {w[31:16], PAD_BYTE, 8'h00};
      3'd3:    r = {w[31:8], PAD_BYTE};
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    if (t < 7'd20) r = (b & c) | (~b & d);
    else if (t < 7'd40) r = b ^ c ^ d;
    else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
    else r = b ^ c ^ d;
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] r;
    if (t < 7'd20) r = K_0;
    else if (t < 7'd40) r = K_1;
    else if (t < 7'd60) r = K_2;
    else r = K_3;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sha1_digest.sv
// ----------------------------------------------------------------------------
// sha1_digest
// Streaming SHA-1: big-endian message words in, five-word digest out.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_axis   in   tdata: msg_word[31:0], word_bytes[34:32]; tlast: last
// m_axis   out  tdata: digest_h0 .. digest_h4, 32 bits each, h0 lowest
//
// Words are accepted while idle; every sixteenth word starts the round pass and
// a chaining update in the single shared round unit, and intake stalls meanwhile.
// A last word adds 2 to 18 padding pushes plus one or two compressions.
// The digest sits in an output register; the next message is accepted while
// it waits, only a following digest stalls on it.
// Reset restores the initial chaining value and a zero length; no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_digest import sha1_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,   // msg_word[31:0], word_bytes[34:32]
  input  wire logic         s_axis_tlast,   // last
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [159:0]      m_axis_tdata    // digest_h0 .. digest_h4
);

  cmd_t cmd;
  sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_bytes_i (s_axis_tdata[34:32]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha1_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .msg_word_i   (s_axis_tdata[31:0]),
    .word_bytes_i (s_axis_tdata[34:32]),
    .last_i       (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .digest_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: hdl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: word intake, padding, round count and digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_digest_macros.svh"

module sha1_ctrl import sha1_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_last_i,
  input  wire logic [2:0] in_bytes_i,
  output logic            in_ready_o,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_PADB  = 7'b000_0010,
    S_FILL  = 7'b000_0100,
    S_LENLO = 7'b000_1000,
    S_ROUND = 7'b001_0000,
    S_CHAIN = 7'b010_0000,
    S_OUT   = 7'b100_0000
  } state_e;

  state_e     state_q, state_d, ret_q, ret_d, nxt;
  logic [3:0] pos_q, pos_d;
  logic [6:0] rnd_q, rnd_d;
  logic       push;
  src_e       src;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    push = 1'b0;
    src  = SRC_IN;
    nxt  = state_q;
    unique case (state_q) inside
      S_IDLE: begin
        push = in_valid_i;
        if (!in_last_i) nxt = S_IDLE;
        else if (in_bytes_i[2]) nxt = S_PADB;
        else nxt = S_FILL;
      end
      S_PADB: begin
        push = 1'b1;
        src  = SRC_PAD;
        nxt  = S_FILL;
      end
      S_FILL: begin
        push = 1'b1;
        if (pos_q == 4'd14) begin
          src = SRC_LENHI;
          nxt = S_LENLO;
        end else begin
          src = SRC_ZERO;
          nxt = S_FILL;
        end
      end
      S_LENLO: begin
        push = 1'b1;
        src  = SRC_LENLO;
        nxt  = S_OUT;
      end
      S_ROUND, S_CHAIN, S_OUT: ;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pos_d   = pos_q;
    rnd_d   = rnd_q;
    cmd_o   = '0;
    cmd_o.push      = push;
    cmd_o.src       = src;
    cmd_o.acc_len   = push && (state_q == S_IDLE);
    cmd_o.round_idx = rnd_q;
    if (push) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'd15) begin
        cmd_o.rnd_load = 1'b1;
        ret_d   = nxt;
        state_d = S_ROUND;
      end else begin
        state_d = nxt;
      end
    end
    unique case (state_q) inside
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (rnd_q == 7'(ROUNDS - 1)) begin
          rnd_d   = '0;
          state_d = S_CHAIN;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      S_CHAIN: begin
        cmd_o.chain_add = 1'b1;
        state_d = ret_q;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_IDLE, S_PADB, S_FILL, S_LENLO: ;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pos_q   <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      rnd_q   <= rnd_d;
    end
  end

  `SHA1_ASSERT(a_rnd_in_round, (rnd_q != 7'd0) |-> (state_q == S_ROUND), "round count outside rounds")
  `SHA1_ASSERT(a_round_pos, (state_q == S_ROUND) |-> (pos_q == 4'd0), "rounds with partial block")
  `SHA1_ASSERT(a_out_pos, (state_q == S_OUT) |-> (pos_q == 4'd0 && ret_q == S_OUT), "digest before final block")
  `SHA1_NEVER_BOTH(a_push_round, cmd_o.push, cmd_o.round_en, "push during rounds")

endmodule

`default_nettype wire

// File: hdl/sha1_dp.sv
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: schedule window, round registers, chaining value, length, output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dp import sha1_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cmd_t         cmd_i,
  output sts_t              sts_o,
  input  wire logic [31:0]  msg_word_i,
  input  wire logic [2:0]   word_bytes_i,
  input  wire logic         last_i,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic [159:0]      digest_o
);

  logic [31:0]  win_q [16];
  logic [31:0]  rr_q [5];
  logic [31:0]  chain_q [5];
  logic [63:0]  len_q;
  logic [159:0] digest_q;
  logic         out_valid_q;

  logic [31:0]  push_w, sched_w, shift_in, tmp;
  logic [2:0]   nsat;
  logic [63:0]  len_inc;

  assign nsat    = word_bytes_i[2] ? 3'd4 : word_bytes_i;
  assign len_inc = last_i ? {58'd0, nsat, 3'b000} : 64'd32;

  always_comb begin
    case (cmd_i.src)
      SRC_IN:    push_w = last_i ? format_last(msg_word_i, word_bytes_i) : msg_word_i;
      SRC_PAD:   push_w = PAD_WORD;
      SRC_ZERO:  push_w = '0;
      SRC_LENHI: push_w = len_q[63:32];
      SRC_LENLO: push_w = len_q[31:0];
      default:   push_w = '0;
    endcase
  end

  assign sched_w  = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
  assign shift_in = cmd_i.push ? push_w : sched_w;
  assign tmp = rotl(rr_q[0], 5) + round_f(cmd_i.round_idx, rr_q[1], rr_q[2], rr_q[3])
             + rr_q[4] + round_k(cmd_i.round_idx) + win_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i + 1];
      win_q[15] <= shift_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd_load) begin
      for (int i = 0; i < 5; i++) rr_q[i] <= chain_q[i];
    end else if (cmd_i.round_en) begin
      rr_q[0] <= tmp;
      rr_q[1] <= rr_q[0];
      rr_q[2] <= rotl(rr_q[1], 30);
      rr_q[3] <= rr_q[2];
      rr_q[4] <= rr_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) chain_q[i] <= INIT_CHAIN[i];
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        for (int i = 0; i < 5; i++) chain_q[i] <= INIT_CHAIN[i];
        len_q <= '0;
      end else begin
        if (cmd_i.chain_add) begin
          for (int i = 0; i < 5; i++) chain_q[i] <= chain_q[i] + rr_q[i];
        end
        if (cmd_i.acc_len) len_q <= len_q + len_inc;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      digest_q <= {chain_q[4], chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign digest_o       = digest_q;

endmodule

`default_nettype wire
